@@ hw/rtl/tss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the tick / sleep scheduler
// field widths, event and op codes, sequencer states, queue entry layout
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int TICK_W     = 32;
	localparam int PID_W      = 4;
	localparam int OP_W       = 2;
	localparam int UNITS_W    = 16;
	localparam int KIND_W     = 3;
	localparam int SLICE_W    = 8;
	localparam int DATA_W     = 32;
	localparam int CFG_ADDR_W = 3;

	// slice length after reset
	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

	// most sleepers released by one tick
	localparam int WAKE_LIMIT = 16;

	// 100 * units as three shifted adds: 64 + 32 + 4
	localparam int WAKE_SH_HI  = 6;
	localparam int WAKE_SH_MID = 5;
	localparam int WAKE_SH_LO  = 2;

	// register index taken from paddr[2]
	localparam logic [0:0] REG_SLICE_LENGTH = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_SLEEP = 2'd1,
		OP_SPAWN = 2'd2
	} tss_op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE    = 3'd0,
		KIND_WOKEN   = 3'd1,
		KIND_PREEMPT = 3'd2,
		KIND_SPAWNED = 3'd3,
		KIND_SLEPT   = 3'd4,
		KIND_REJECT  = 3'd5
	} tss_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WCHK,
		ST_SLICE,
		ST_MUL1,
		ST_MUL2,
		ST_SCAN,
		ST_SHIFT,
		ST_INS,
		ST_DONE
	} tss_state_t;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [TICK_W-1:0] wake;
	} tss_entry_t;

	typedef struct packed {
		tss_kind_t        kind;
		logic [PID_W-1:0] pid;
	} tss_evt_t;

	typedef struct packed {
		logic [TICK_W-1:0] a;
		logic [TICK_W-1:0] b;
		logic              sub;
	} tss_alu_req_t;

	typedef struct packed {
		logic [TICK_W-1:0] res;
		logic              not_after;
	} tss_alu_rsp_t;

endpackage

@@ hw/rtl/tss_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ram: generic simple dual port ram
// one write port, one read port with registered read data held when idle
// ----------------------------------------------------------------------------
module tss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/tss_alu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_alu: shared 32-bit add / subtract unit
// builds wake ticks, advances the tick count, does wrap-aware order tests
// ----------------------------------------------------------------------------
module tss_alu (
	input  tss_pkg::tss_alu_req_t req,
	output tss_pkg::tss_alu_rsp_t rsp
);
	import tss_pkg::*;

	logic [TICK_W-1:0] b_op;
	logic [TICK_W-1:0] sum;

	assign b_op = req.sub ? ~req.b : req.b;
	assign sum  = req.a + b_op + TICK_W'(req.sub);

	// a at or before b: difference zero or negative
	assign rsp.res       = sum;
	assign rsp.not_after = (sum == '0) || sum[TICK_W-1];

endmodule

@@ hw/rtl/tick_sleep_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_sleep_scheduler: tick, sleep and spawn helper for a time-sliced kernel
// sorted sleep queue in ram, per-process slice counters, one shared adder
// ----------------------------------------------------------------------------
// One request beat is worked at a time; req_stall is high until its last
// event beat sits in the output register. A sleep does a forward scan over
// the entries that wake no later, then a one-entry-per-cycle shift of the
// rest. The sequencing comes from the single read port of the queue ram and
// the single 32-bit adder, which serves the tick increment, the 100x wake
// product (three shifted adds) and every wrap-aware order test. Output
// stalls can hold the sequencer. The queue is a circular buffer (head
// pointer plus fill count), so a release only moves the head pointer. Slice
// counters reset through one valid bit per process, so there is no clearing
// pass after reset. slice_length (paddr 0) may be written only while the
// block is idle.
// ----------------------------------------------------------------------------
module tick_sleep_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int NUM_PROCS   = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tss_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [tss_pkg::DATA_W-1:0]       pwdata,
	output logic [tss_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	// request channel
	input  logic                             req_valid,
	output logic                             req_stall,
	input  logic [tss_pkg::OP_W-1:0]         op,
	input  logic [tss_pkg::PID_W-1:0]        pid,
	input  logic [tss_pkg::UNITS_W-1:0]      sleep_units,
	// event channel
	output logic                             evt_valid,
	input  logic                             evt_stall,
	output logic [tss_pkg::KIND_W-1:0]       kind,
	output logic [tss_pkg::PID_W-1:0]        ready_pid,
	output logic                             last
);
	import tss_pkg::*;

	localparam int QW      = $clog2(QUEUE_DEPTH);
	localparam int CW      = $clog2(QUEUE_DEPTH + 1);
	localparam int PW      = $clog2(NUM_PROCS);
	localparam int WKW     = $clog2(WAKE_LIMIT + 1);
	localparam int ENTRY_W = $bits(tss_entry_t);

	// sequencer and architectural state
	tss_state_t        state_q, state_d;
	logic [TICK_W-1:0] tick_q;
	logic [QW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     sh_q;
	logic [WKW-1:0]    woken_q;
	logic [SLICE_W-1:0] slice_len_q;
	logic [NUM_PROCS-1:0] s_valid_q;

	// captured request and work registers
	logic [PID_W-1:0]   pid_q;
	logic [UNITS_W-1:0] units_q;
	logic [TICK_W-1:0]  wake_q;

	// one event held back until we know whether another follows
	logic     pend_valid_q;
	tss_evt_t pend_q;

	// output register
	logic     evt_valid_q;
	tss_evt_t evt_q;
	logic     evt_last_q;

	// shared adder
	tss_alu_req_t alu_req;
	tss_alu_rsp_t alu_rsp;

	// queue ram ports
	logic               q_rd_en, q_wr_en;
	logic [CW-1:0]      q_rd_l, q_wr_l;
	logic [QW-1:0]      q_rd_addr, q_wr_addr;
	tss_entry_t         q_wr_data;
	logic [ENTRY_W-1:0] q_rd_data;
	tss_entry_t         q_entry;

	// slice ram ports
	logic               s_rd_en, s_wr_en;
	logic [PW-1:0]      s_rd_addr;
	logic [SLICE_W-1:0] s_rd_data;

	// conditions
	logic               req_acc, out_free, can_push;
	logic               pid_ok_in, reject, counted;
	logic               wk_more, scan_more, sh_last, preempt;
	logic [PW-1:0]      pid_idx_q;
	logic [SLICE_W-1:0] used;
	logic [SLICE_W:0]   slice_c;
	logic               cfg_we;

	// register controls
	logic          capture, tick_ld, wake_ld, pop, cnt_inc;
	logic          woken_clr, woken_inc, idx_clr, idx_inc, sh_ld, sh_dec;
	logic          sv_clr, sv_set;
	logic [PW-1:0] sv_addr;
	logic          push_en, flush_en, evt_load;
	tss_evt_t      push_evt;

	// logical queue slot to ram address, wrapping at the queue depth
	function automatic logic [QW-1:0] phys(input logic [QW-1:0] head,
		input logic [CW-1:0] l);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(l);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[QW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite &&
		(paddr[CFG_ADDR_W-1:2] == REG_SLICE_LENGTH);
	assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_SLICE_LENGTH) ?
		DATA_W'(slice_len_q) : '0;

	// ------------------------------------------------------------------
	// handshakes
	// ------------------------------------------------------------------
	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	// output register can take a beat this cycle
	assign out_free  = !evt_valid_q || !evt_stall;
	// a new event fits if nothing is held back or the held one can move on
	assign can_push  = !pend_valid_q || out_free;

	assign evt_valid = evt_valid_q;
	assign kind      = evt_q.kind;
	assign ready_pid = evt_q.pid;
	assign last      = evt_last_q;

	// ------------------------------------------------------------------
	// storage
	// ------------------------------------------------------------------
	assign q_rd_addr = phys(head_q, q_rd_l);
	assign q_wr_addr = phys(head_q, q_wr_l);
	assign q_entry   = tss_entry_t'(q_rd_data);

	tss_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk     (clk),
		.wr_en   (q_wr_en),
		.wr_addr (q_wr_addr),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_addr (q_rd_addr),
		.rd_data (q_rd_data)
	);

	tss_ram #(
		.WIDTH (SLICE_W),
		.DEPTH (NUM_PROCS)
	) u_slice_ram (
		.clk     (clk),
		.wr_en   (s_wr_en),
		.wr_addr (pid_idx_q),
		.wr_data (slice_c[SLICE_W-1:0]),
		.rd_en   (s_rd_en),
		.rd_addr (s_rd_addr),
		.rd_data (s_rd_data)
	);

	tss_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// ------------------------------------------------------------------
	// conditions
	// ------------------------------------------------------------------
	assign pid_ok_in = (int'(pid) < NUM_PROCS);
	assign reject    = !pid_ok_in || (count_q == CW'(QUEUE_DEPTH));
	assign pid_idx_q = PW'(pid_q);
	// idle process and out-of-range pids are never slice-counted
	assign counted   = (pid_q != '0) && (int'(pid_q) < NUM_PROCS);

	// a counter whose valid bit is clear reads as zero
	assign used    = s_valid_q[pid_idx_q] ? s_rd_data : '0;
	assign slice_c = {1'b0, used} + (SLICE_W+1)'(1);
	assign preempt = (slice_c >= {1'b0, slice_len_q});

	// head is due, queue not empty and release budget left
	assign wk_more   = (count_q != '0) && (woken_q != WKW'(WAKE_LIMIT)) &&
		alu_rsp.not_after;
	// scanned entry wakes no later than the new one
	assign scan_more = (idx_q != count_q) && alu_rsp.not_after;
	assign sh_last   = ((sh_q - CW'(1)) == idx_q);

	// ------------------------------------------------------------------
	// adder operand select
	// ------------------------------------------------------------------
	always_comb begin
		alu_req.a   = tick_q;
		alu_req.b   = TICK_W'(1);
		alu_req.sub = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// tick: tick + 1, sleep: tick + 64 * units
				if (tss_op_t'(op) == OP_SLEEP) begin
					alu_req.b = TICK_W'(sleep_units) << WAKE_SH_HI;
				end
			end
			ST_MUL1: begin
				alu_req.a = wake_q;
				alu_req.b = TICK_W'(units_q) << WAKE_SH_MID;
			end
			ST_MUL2: begin
				alu_req.a = wake_q;
				alu_req.b = TICK_W'(units_q) << WAKE_SH_LO;
			end
			ST_WCHK: begin
				alu_req.a   = q_entry.wake;
				alu_req.b   = tick_q;
				alu_req.sub = 1'b1;
			end
			ST_SCAN: begin
				alu_req.a   = q_entry.wake;
				alu_req.b   = wake_q;
				alu_req.sub = 1'b1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (tss_op_t'(op))
						OP_TICK:  state_d = ST_WCHK;
						OP_SLEEP: state_d = reject ? ST_DONE : ST_MUL1;
						OP_SPAWN: state_d = ST_DONE;
						default:  state_d = ST_DONE;
					endcase
				end
			end
			ST_WCHK: begin
				if (!wk_more) begin
					state_d = ST_SLICE;
				end
			end
			ST_SLICE: begin
				if (!(counted && preempt && !can_push)) begin
					state_d = ST_DONE;
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_SCAN;
			ST_SCAN: begin
				if (!scan_more) begin
					state_d = (idx_q == count_q) ? ST_INS : ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (sh_last) begin
					state_d = ST_INS;
				end
			end
			ST_INS: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer outputs
	// ------------------------------------------------------------------
	always_comb begin
		capture   = 1'b0;
		tick_ld   = 1'b0;
		wake_ld   = 1'b0;
		pop       = 1'b0;
		cnt_inc   = 1'b0;
		woken_clr = 1'b0;
		woken_inc = 1'b0;
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		sh_ld     = 1'b0;
		sh_dec    = 1'b0;
		sv_clr    = 1'b0;
		sv_set    = 1'b0;
		sv_addr   = pid_idx_q;
		q_rd_en   = 1'b0;
		q_rd_l    = '0;
		q_wr_en   = 1'b0;
		q_wr_l    = '0;
		q_wr_data = q_entry;
		s_rd_en   = 1'b0;
		s_rd_addr = PW'(pid);
		s_wr_en   = 1'b0;
		push_en   = 1'b0;
		push_evt  = '{kind: KIND_NONE, pid: '0};
		flush_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					capture = 1'b1;
					case (tss_op_t'(op))
						OP_TICK: begin
							// advance time, fetch queue head and slice count
							tick_ld   = 1'b1;
							q_rd_en   = 1'b1;
							s_rd_en   = 1'b1;
							woken_clr = 1'b1;
						end
						OP_SLEEP: begin
							if (reject) begin
								push_en  = 1'b1;
								push_evt = '{kind: KIND_REJECT, pid: pid};
							end else begin
								wake_ld = 1'b1;
							end
						end
						OP_SPAWN: begin
							if (pid_ok_in) begin
								sv_clr  = 1'b1;
								sv_addr = PW'(pid);
								if (pid != '0) begin
									push_en  = 1'b1;
									push_evt = '{kind: KIND_SPAWNED, pid: pid};
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_WCHK: begin
				// release the head, fetch the next one
				if (wk_more && can_push) begin
					push_en   = 1'b1;
					push_evt  = '{kind: KIND_WOKEN, pid: q_entry.pid};
					pop       = 1'b1;
					woken_inc = 1'b1;
					q_rd_en   = 1'b1;
					q_rd_l    = CW'(1);
				end
			end
			ST_SLICE: begin
				if (counted) begin
					if (preempt) begin
						if (can_push) begin
							push_en  = 1'b1;
							push_evt = '{kind: KIND_PREEMPT, pid: pid_q};
							sv_clr   = 1'b1;
						end
					end else begin
						s_wr_en = 1'b1;
						sv_set  = 1'b1;
					end
				end
			end
			ST_MUL1: begin
				wake_ld = 1'b1;
			end
			ST_MUL2: begin
				// last product step, start the scan at the head
				wake_ld = 1'b1;
				q_rd_en = 1'b1;
				idx_clr = 1'b1;
			end
			ST_SCAN: begin
				if (scan_more) begin
					idx_inc = 1'b1;
					q_rd_en = 1'b1;
					q_rd_l  = idx_q + CW'(1);
				end else if (idx_q != count_q) begin
					// open a gap at idx_q, moving entries up from the tail
					sh_ld   = 1'b1;
					q_rd_en = 1'b1;
					q_rd_l  = count_q - CW'(1);
				end
			end
			ST_SHIFT: begin
				q_wr_en = 1'b1;
				q_wr_l  = sh_q;
				sh_dec  = 1'b1;
				if (!sh_last) begin
					q_rd_en = 1'b1;
					q_rd_l  = sh_q - CW'(2);
				end
			end
			ST_INS: begin
				q_wr_en   = 1'b1;
				q_wr_l    = idx_q;
				q_wr_data = '{pid: pid_q, wake: wake_q};
				cnt_inc   = 1'b1;
				push_en   = 1'b1;
				push_evt  = '{kind: KIND_SLEPT, pid: pid_q};
			end
			ST_DONE: begin
				if (out_free) begin
					flush_en = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// held event moves out on a new push (not last) or at the end (last)
	assign evt_load = flush_en || (push_en && pend_valid_q);

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tick_q       <= '0;
			head_q       <= '0;
			count_q      <= '0;
			idx_q        <= '0;
			sh_q         <= '0;
			woken_q      <= '0;
			slice_len_q  <= SLICE_RESET;
			s_valid_q    <= '0;
			pend_valid_q <= 1'b0;
			evt_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				slice_len_q <= pwdata[SLICE_W-1:0];
			end
			if (tick_ld) begin
				tick_q <= alu_rsp.res;
			end
			if (pop) begin
				head_q  <= phys(head_q, CW'(1));
				count_q <= count_q - CW'(1);
			end else if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (woken_clr) begin
				woken_q <= '0;
			end else if (woken_inc) begin
				woken_q <= woken_q + WKW'(1);
			end
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (sh_ld) begin
				sh_q <= count_q;
			end else if (sh_dec) begin
				sh_q <= sh_q - CW'(1);
			end
			if (sv_clr) begin
				s_valid_q[sv_addr] <= 1'b0;
			end else if (sv_set) begin
				s_valid_q[sv_addr] <= 1'b1;
			end
			if (push_en) begin
				pend_valid_q <= 1'b1;
			end else if (flush_en) begin
				pend_valid_q <= 1'b0;
			end
			if (evt_load) begin
				evt_valid_q <= 1'b1;
			end else if (!evt_stall) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (capture) begin
			pid_q   <= pid;
			units_q <= sleep_units;
		end
		if (wake_ld) begin
			wake_q <= alu_rsp.res;
		end
		if (push_en) begin
			pend_q <= push_evt;
		end
		if (evt_load) begin
			// nothing held back at the end means an empty item
			evt_q      <= pend_valid_q ? pend_q : tss_evt_t'{kind: KIND_NONE, pid: '0};
			evt_last_q <= flush_en;
		end
	end

endmodule
